// ===== rtl/core/arp_responder_one_entry_cache_assert.svh =====
// Assertion macros for the ARP responder core.
// Used by the modules that check their own logic; no other dependencies.
`ifndef ARP_RESPONDER_ONE_ENTRY_CACHE_ASSERT_SVH
`define ARP_RESPONDER_ONE_ENTRY_CACHE_ASSERT_SVH

// same-cycle implication, sampled on clk, off during rst
`define ARPC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define ARPC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/arpc_pkg.sv =====
// Shared types, codes and frame layout for the ARP responder core.
// No dependencies; used by every module of the core.
`timescale 1ns / 1ps
`default_nettype none
package arpc_pkg;

  localparam int MAX_FRAME_LEN_DEF = 2048;
  localparam int JOBQ_DEPTH = 4;

  localparam logic [15:0] ETYPE_ARP = 16'h0806;
  localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
  localparam logic [7:0] BCAST_BYTE = 8'hFF;
  localparam int ETH_HDR_LEN = 14;

  localparam logic [15:0] ARP_HTYPE_ETH = 16'd1;
  localparam logic [7:0] ARP_HLEN = 8'd6;
  localparam logic [7:0] ARP_PLEN = 8'd4;
  localparam logic [15:0] ARP_OPC_REQUEST = 16'd1;
  localparam logic [15:0] ARP_OPC_REPLY = 16'd2;

  // byte positions within an ARP frame
  localparam int POS_DST = 0;
  localparam int POS_SRC = 6;
  localparam int POS_ETYPE = ETH_HDR_LEN - 2;
  localparam int POS_HTYPE = ETH_HDR_LEN;
  localparam int POS_PTYPE = ETH_HDR_LEN + 2;
  localparam int POS_HLEN = ETH_HDR_LEN + 4;
  localparam int POS_PLEN = ETH_HDR_LEN + 5;
  localparam int POS_OP = ETH_HDR_LEN + 6;
  localparam int POS_SHA = ETH_HDR_LEN + 8;
  localparam int POS_SPA = ETH_HDR_LEN + 14;
  localparam int POS_THA = ETH_HDR_LEN + 18;
  localparam int POS_TPA = ETH_HDR_LEN + 24;
  localparam int ARP_FRAME_LEN = ETH_HDR_LEN + 28;
  localparam int IDX_W = $clog2(ARP_FRAME_LEN);

  localparam logic CMD_RX_BYTE = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  localparam logic REG_OWN_MAC = 1'b0;
  localparam logic REG_OWN_IP = 1'b1;

  typedef logic [1:0] kind_t;
  localparam kind_t KIND_REPLY = 2'd0;
  localparam kind_t KIND_REQUEST = 2'd1;
  localparam kind_t KIND_HIT = 2'd2;

  typedef struct packed {
    kind_t kind;
    logic [47:0] mac;
    logic [31:0] ip;
  } job_t;

  typedef struct packed {
    logic valid;
    job_t job;
  } jobq_push_t;

  typedef struct packed {
    logic full;
    logic empty;
  } jobq_stat_t;

  function automatic logic [7:0] mac_byte(input logic [47:0] mac, input logic [2:0] off);
    logic [47:0] s;
    s = mac << (8 * off);
    return s[47:40];
  endfunction

  function automatic logic [7:0] ip_byte(input logic [31:0] ip, input logic [1:0] off);
    logic [31:0] s;
    s = ip << (8 * off);
    return s[31:24];
  endfunction

  // One byte of an outgoing ARP frame for a reply or request job.
  function automatic logic [7:0] frame_byte(input job_t j, input logic [47:0] own_mac,
                                            input logic [31:0] own_ip,
                                            input logic [IDX_W-1:0] idx);
    logic reply;
    logic [47:0] dst;
    logic [47:0] tgt;
    logic [15:0] op;
    logic [7:0] b;
    reply = (j.kind == KIND_REPLY);
    dst = reply ? j.mac : {6{BCAST_BYTE}};
    tgt = reply ? j.mac : 48'd0;
    op = reply ? ARP_OPC_REPLY : ARP_OPC_REQUEST;
    unique case (idx) inside
      [POS_DST:POS_SRC-1]:         b = mac_byte(dst, 3'(idx - IDX_W'(POS_DST)));
      [POS_SRC:POS_ETYPE-1]:       b = mac_byte(own_mac, 3'(idx - IDX_W'(POS_SRC)));
      IDX_W'(POS_ETYPE):           b = ETYPE_ARP[15:8];
      IDX_W'(POS_ETYPE + 1):       b = ETYPE_ARP[7:0];
      IDX_W'(POS_HTYPE):           b = ARP_HTYPE_ETH[15:8];
      IDX_W'(POS_HTYPE + 1):       b = ARP_HTYPE_ETH[7:0];
      IDX_W'(POS_PTYPE):           b = ETYPE_IPV4[15:8];
      IDX_W'(POS_PTYPE + 1):       b = ETYPE_IPV4[7:0];
      IDX_W'(POS_HLEN):            b = ARP_HLEN;
      IDX_W'(POS_PLEN):            b = ARP_PLEN;
      IDX_W'(POS_OP):              b = op[15:8];
      IDX_W'(POS_OP + 1):          b = op[7:0];
      [POS_SHA:POS_SPA-1]:         b = mac_byte(own_mac, 3'(idx - IDX_W'(POS_SHA)));
      [POS_SPA:POS_THA-1]:         b = ip_byte(own_ip, 2'(idx - IDX_W'(POS_SPA)));
      [POS_THA:POS_TPA-1]:         b = mac_byte(tgt, 3'(idx - IDX_W'(POS_THA)));
      [POS_TPA:ARP_FRAME_LEN-1]:   b = ip_byte(j.ip, 2'(idx - IDX_W'(POS_TPA)));
      default:                     b = 8'd0;
    endcase
    return b;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/arp_responder_one_entry_cache.sv =====
// Top level of the ARP responder with a one-entry address cache.
// Depends on arpc_pkg, arpc_front, arpc_jobq and arpc_emit.
//
// Items (received frame bytes or cache lookups) are taken one per clock as long as the
// four-entry job queue between the receive front and the transmit back has room;
// item_stall rises only while that queue is full. A frame byte updates the parser in the
// cycle it is taken; an ARP request for own_ip, or a lookup that misses, queues a job that
// leaves as 42 result words, one per clock while result_stall is low; a lookup hit leaves
// as a single word. Jobs drain back to back with no gap, so the output side sets the
// sustained rate whenever jobs arrive faster than it can drain them.
// Configuration writes are always ready and take effect on the next clock.
`timescale 1ns / 1ps
`default_nettype none
module arp_responder_one_entry_cache #(
  parameter int MAX_FRAME_LEN = arpc_pkg::MAX_FRAME_LEN_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic         cfg_index,
  input  wire logic [47:0]  cfg_data,
  input  wire logic         item_valid,
  output logic              item_stall,
  input  wire logic         cmd,
  input  wire logic [7:0]   rx_byte,
  input  wire logic         frame_end,
  input  wire logic [31:0]  query_ip,
  output logic              result_valid,
  input  wire logic         result_stall,
  output logic [1:0]        kind,
  output logic [7:0]        tx_byte,
  output logic              tx_last,
  output logic [47:0]       found_mac
);

  logic [47:0] own_mac;
  logic [31:0] own_ip;

  arpc_pkg::jobq_push_t push;
  arpc_pkg::jobq_stat_t qs;
  arpc_pkg::job_t head;
  logic pop;

  assign cfg_ready = 1'b1;
  assign item_stall = qs.full;

  always_ff @(posedge clk) begin
    if (rst) begin
      own_mac <= '0;
      own_ip <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        arpc_pkg::REG_OWN_MAC: own_mac <= cfg_data;
        arpc_pkg::REG_OWN_IP:  own_ip <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  arpc_front #(
    .MAX_FRAME_LEN(MAX_FRAME_LEN)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .cmd        (cmd),
    .rx_byte    (rx_byte),
    .frame_end  (frame_end),
    .query_ip   (query_ip),
    .own_ip     (own_ip),
    .push       (push)
  );

  arpc_jobq #(
    .DEPTH(arpc_pkg::JOBQ_DEPTH)
  ) u_jobq (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .pop  (pop),
    .head (head),
    .stat (qs)
  );

  arpc_emit u_emit (
    .clk          (clk),
    .rst          (rst),
    .qs           (qs),
    .head         (head),
    .own_mac      (own_mac),
    .own_ip       (own_ip),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .kind         (kind),
    .tx_byte      (tx_byte),
    .tx_last      (tx_last),
    .found_mac    (found_mac)
  );

endmodule
`default_nettype wire

// ===== rtl/core/arpc_jobq.sv =====
// Short job queue between the receive front and the transmit back.
// Depends on arpc_pkg for the job word and status types.
`timescale 1ns / 1ps
`default_nettype none
module arpc_jobq #(
  parameter int DEPTH = arpc_pkg::JOBQ_DEPTH
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire arpc_pkg::jobq_push_t push,
  input  wire logic                pop,
  output arpc_pkg::job_t           head,
  output arpc_pkg::jobq_stat_t     stat
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  arpc_pkg::job_t mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic do_push;
  logic do_pop;

  always_comb begin
    stat.full = (count == CNT_W'(DEPTH));
    stat.empty = (count == '0);
    do_push = push.valid && !stat.full;
    do_pop = pop && !stat.empty;
    head = mem[rd_ptr];
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push.job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/arpc_front.sv =====
// Receive front: parses frame bytes, keeps the one-entry cache, classifies items into jobs.
// Depends on arpc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module arpc_front #(
  parameter int MAX_FRAME_LEN = arpc_pkg::MAX_FRAME_LEN_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 item_valid,
  input  wire logic                 item_stall,
  input  wire logic                 cmd,
  input  wire logic [7:0]           rx_byte,
  input  wire logic                 frame_end,
  input  wire logic [31:0]          query_ip,
  input  wire logic [31:0]          own_ip,
  output arpc_pkg::jobq_push_t      push
);

  localparam int POS_W = $clog2(MAX_FRAME_LEN);
  localparam logic [POS_W-1:0] POS_SAT = POS_W'(MAX_FRAME_LEN - 1);

  logic [POS_W-1:0] pos;
  logic [15:0] ethertype;
  logic [15:0] opcode;
  logic [47:0] peer_mac;
  logic [31:0] peer_ip;
  logic [31:0] asked_ip;
  logic [31:0] cached_ip;
  logic [47:0] cached_mac;
  logic cache_valid;

  logic accept;
  logic rx_accept;
  logic [31:0] asked_ip_next;
  logic arp_ok;
  logic learn;
  logic answer;
  logic hit;

  always_comb begin
    accept = item_valid && !item_stall;
    rx_accept = accept && (cmd == arpc_pkg::CMD_RX_BYTE);
    asked_ip_next = asked_ip;
    if (pos >= POS_W'(arpc_pkg::POS_TPA) && pos < POS_W'(arpc_pkg::ARP_FRAME_LEN)) begin
      asked_ip_next = {asked_ip[23:0], rx_byte};
    end
    arp_ok = frame_end && (pos >= POS_W'(arpc_pkg::ARP_FRAME_LEN - 1))
             && (ethertype == arpc_pkg::ETYPE_ARP);
    learn = arp_ok && ((opcode == arpc_pkg::ARP_OPC_REQUEST)
                       || (opcode == arpc_pkg::ARP_OPC_REPLY));
    answer = arp_ok && (opcode == arpc_pkg::ARP_OPC_REQUEST) && (asked_ip_next == own_ip);
    hit = cache_valid && (cached_ip == query_ip);

    push.valid = accept && ((cmd == arpc_pkg::CMD_LOOKUP) || answer);
    if (cmd == arpc_pkg::CMD_LOOKUP) begin
      if (hit) begin
        push.job = '{kind: arpc_pkg::KIND_HIT, mac: cached_mac, ip: 32'd0};
      end else begin
        push.job = '{kind: arpc_pkg::KIND_REQUEST, mac: 48'd0, ip: query_ip};
      end
    end else begin
      push.job = '{kind: arpc_pkg::KIND_REPLY, mac: peer_mac, ip: peer_ip};
    end
  end

  // capture header fields by position
  always_ff @(posedge clk) begin
    if (rx_accept) begin
      if (pos == POS_W'(arpc_pkg::POS_ETYPE) || pos == POS_W'(arpc_pkg::POS_ETYPE + 1)) begin
        ethertype <= {ethertype[7:0], rx_byte};
      end
      if (pos == POS_W'(arpc_pkg::POS_OP) || pos == POS_W'(arpc_pkg::POS_OP + 1)) begin
        opcode <= {opcode[7:0], rx_byte};
      end
      if (pos >= POS_W'(arpc_pkg::POS_SHA) && pos < POS_W'(arpc_pkg::POS_SPA)) begin
        peer_mac <= {peer_mac[39:0], rx_byte};
      end
      if (pos >= POS_W'(arpc_pkg::POS_SPA) && pos < POS_W'(arpc_pkg::POS_THA)) begin
        peer_ip <= {peer_ip[23:0], rx_byte};
      end
      asked_ip <= asked_ip_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
      cached_ip <= '0;
      cached_mac <= '0;
      cache_valid <= 1'b0;
    end else if (rx_accept) begin
      if (frame_end) begin
        pos <= '0;
      end else if (pos != POS_SAT) begin
        pos <= pos + 1'b1;
      end
      if (learn) begin
        cached_ip <= peer_ip;
        cached_mac <= peer_mac;
        cache_valid <= 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/arpc_emit.sv =====
// Transmit back: drains jobs into result words, one frame byte or lookup answer a cycle while result_stall is low.
// Depends on arpc_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "arp_responder_one_entry_cache_assert.svh"
module arpc_emit (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire arpc_pkg::jobq_stat_t qs,
  input  wire arpc_pkg::job_t       head,
  input  wire logic [47:0]          own_mac,
  input  wire logic [31:0]          own_ip,
  output logic                      pop,
  output logic                      result_valid,
  input  wire logic                 result_stall,
  output arpc_pkg::kind_t           kind,
  output logic [7:0]                tx_byte,
  output logic                      tx_last,
  output logic [47:0]               found_mac
);

  localparam int IDX_W = arpc_pkg::IDX_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(arpc_pkg::ARP_FRAME_LEN - 1);

  arpc_pkg::job_t cur;
  logic [IDX_W-1:0] idx;
  logic busy;

  arpc_pkg::job_t sel;
  logic [IDX_W-1:0] idx_sel;
  logic advance;
  logic have;
  logic sel_hit;
  logic last_sel;

  always_comb begin
    advance = !result_valid || !result_stall;
    have = busy || !qs.empty;
    sel = busy ? cur : head;
    idx_sel = busy ? idx : '0;
    sel_hit = (sel.kind == arpc_pkg::KIND_HIT);
    last_sel = sel_hit || (idx_sel == LAST_IDX);
    pop = advance && !busy && !qs.empty;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      busy <= 1'b0;
    end else if (advance) begin
      result_valid <= have;
      if (have) begin
        busy <= !last_sel;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && have) begin
      kind <= sel.kind;
      tx_byte <= sel_hit ? 8'd0 : arpc_pkg::frame_byte(sel, own_mac, own_ip, idx_sel);
      tx_last <= last_sel;
      found_mac <= sel_hit ? sel.mac : 48'd0;
      cur <= sel;
      idx <= idx_sel + 1'b1;
    end
  end

  `ARPC_ASSERT_NOW(a_idx_range, busy, (idx != '0) && (idx <= LAST_IDX), "frame index out of range")
  `ARPC_ASSERT_NOW(a_start_from_queue, busy && !$past(busy), !$past(qs.empty), "frame started without a job")
  `ARPC_ASSERT_NOW(a_mac_only_on_hit, result_valid && (kind != arpc_pkg::KIND_HIT), found_mac == 48'd0, "found_mac set on frame word")
  `ARPC_ASSERT_NEXT(a_hit_single, advance && have && sel_hit, !busy, "hit answer opened a frame")

endmodule
`default_nettype wire

// ===== test/tb.sv =====
// Self-checking testbench for arp_responder_one_entry_cache.
// Drives frame bytes, lookups and register writes, and predicts every result word.
// Depends on arpc_pkg and the arp_responder_one_entry_cache RTL only.
`timescale 1ns / 1ps
module tb;
  import arpc_pkg::*;

  localparam int FRAME_CAP = 64;
  localparam int SETTLE_CYCLES = 16;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int RANDOM_STEPS = 2;

  typedef enum logic [1:0] {ST_FRAME, ST_LOOKUP, ST_SET_MAC, ST_SET_IP} step_e;
  typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_HIT} chk_e;

  typedef struct {
    step_e what;
    chk_e chk;
    logic [15:0] etype;
    logic [15:0] op;
    logic [47:0] mac;
    logic [31:0] sip;
    logic [31:0] tip;
    int len;
    int mid_at;
    logic [31:0] ip;
    logic junk;
  } step_t;

  typedef struct packed {
    kind_t kind;
    logic [7:0] data;
    logic last;
    logic [47:0] mac;
  } word_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_valid;
  logic cfg_ready;
  logic cfg_index;
  logic [47:0] cfg_data;
  logic item_valid;
  logic item_stall;
  logic cmd;
  logic [7:0] rx_byte;
  logic frame_end;
  logic [31:0] query_ip;
  logic result_valid;
  logic result_stall = 1'b0;
  kind_t kind;
  logic [7:0] tx_byte;
  logic tx_last;
  logic [47:0] found_mac;

  // predictor state
  logic [47:0] stn_mac = '0;
  logic [31:0] stn_ip = '0;
  int rx_pos = 0;
  logic [15:0] got_etype = '0;
  logic [15:0] got_op = '0;
  logic [47:0] src_mac = '0;
  logic [31:0] src_ip = '0;
  logic [31:0] dst_ip = '0;
  logic [31:0] entry_ip = '0;
  logic [47:0] entry_mac = '0;
  logic entry_ok = 1'b0;
  word_t pending_words[$];
  logic mute_model = 1'b0;

  chk_e row_chk = CHK_MODEL;
  logic [47:0] typed_mac = '0;
  int idle_pct = 0;
  int stall_pct = 0;
  int idle_mix[4] = '{0, 65, 0, 13};
  int stall_mix[4] = '{0, 0, 65, 13};
  logic [31:0] peer_pool[4];
  step_t plan[$];
  int errors = 0;
  int cycle_count = 0;

  arp_responder_one_entry_cache #(
    .MAX_FRAME_LEN(FRAME_CAP)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .cmd(cmd),
    .rx_byte(rx_byte),
    .frame_end(frame_end),
    .query_ip(query_ip),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .kind(kind),
    .tx_byte(tx_byte),
    .tx_last(tx_last),
    .found_mac(found_mac)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(negedge clk) begin
    result_stall <= !rst && ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("arp_responder_one_entry_cache verification failed");
      $finish;
    end
  end

  function automatic void note_error(string msg);
    errors++;
    if (errors <= 10) $display("%0t: %s", $time, msg);
  endfunction

  function automatic void queue_word(kind_t k, logic [7:0] b, logic l, logic [47:0] m);
    word_t w;
    w.kind = k;
    w.data = b;
    w.last = l;
    w.mac = m;
    if (!mute_model) pending_words.push_back(w);
  endfunction

  function automatic void queue_arp_frame(kind_t k, logic [47:0] dst, logic [15:0] op,
                                          logic [47:0] tmac, logic [31:0] tip);
    logic [ARP_FRAME_LEN*8-1:0] f;
    f = {dst, stn_mac, ETYPE_ARP, ARP_HTYPE_ETH, ETYPE_IPV4, ARP_HLEN, ARP_PLEN, op,
         stn_mac, stn_ip, tmac, tip};
    for (int i = 0; i < ARP_FRAME_LEN; i++)
      queue_word(k, f[(ARP_FRAME_LEN-1-i)*8 +: 8], i == ARP_FRAME_LEN - 1, 48'd0);
  endfunction

  function automatic void predict_item(logic c, logic [7:0] b, logic e, logic [31:0] q);
    int len;
    if (c == CMD_LOOKUP) begin
      if (entry_ok && entry_ip == q) queue_word(KIND_HIT, 8'd0, 1'b1, entry_mac);
      else queue_arp_frame(KIND_REQUEST, {6{BCAST_BYTE}}, ARP_OPC_REQUEST, 48'd0, q);
      return;
    end
    if (rx_pos == POS_ETYPE || rx_pos == POS_ETYPE + 1) got_etype = {got_etype[7:0], b};
    else if (rx_pos == POS_OP || rx_pos == POS_OP + 1) got_op = {got_op[7:0], b};
    else if (rx_pos >= POS_SHA && rx_pos < POS_SPA) src_mac = {src_mac[39:0], b};
    else if (rx_pos >= POS_SPA && rx_pos < POS_THA) src_ip = {src_ip[23:0], b};
    else if (rx_pos >= POS_TPA && rx_pos < ARP_FRAME_LEN) dst_ip = {dst_ip[23:0], b};
    len = rx_pos + 1;
    if (rx_pos < FRAME_CAP - 1) rx_pos++;
    if (!e) return;
    rx_pos = 0;
    if (len < ARP_FRAME_LEN || got_etype != ETYPE_ARP) return;
    if (got_op == ARP_OPC_REQUEST || got_op == ARP_OPC_REPLY) begin
      entry_ip = src_ip;
      entry_mac = src_mac;
      entry_ok = 1'b1;
    end
    if (got_op == ARP_OPC_REQUEST && dst_ip == stn_ip)
      queue_arp_frame(KIND_REPLY, src_mac, ARP_OPC_REPLY, src_mac, src_ip);
  endfunction

  always @(posedge clk) begin
    word_t want;
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_OWN_MAC) stn_mac = cfg_data;
        else stn_ip = cfg_data[31:0];
      end
      if (item_valid && !item_stall) begin
        mute_model = (row_chk != CHK_MODEL);
        predict_item(cmd, rx_byte, frame_end, query_ip);
        mute_model = 1'b0;
        if (row_chk == CHK_HIT) queue_word(KIND_HIT, 8'd0, 1'b1, typed_mac);
      end
      if (result_valid && !result_stall) begin
        if (pending_words.size() == 0) begin
          note_error($sformatf("unexpected word: kind %0d byte %02h last %0d mac %012h",
                               kind, tx_byte, tx_last, found_mac));
        end else begin
          want = pending_words.pop_front();
          if (kind !== want.kind || tx_byte !== want.data || tx_last !== want.last ||
              found_mac !== want.mac)
            note_error($sformatf({"word mismatch: expected kind %0d byte %02h last %0d ",
                                  "mac %012h, got kind %0d byte %02h last %0d mac %012h"},
                                 want.kind, want.data, want.last, want.mac,
                                 kind, tx_byte, tx_last, found_mac));
        end
      end
    end
  end

  function automatic step_t arp_step(chk_e c, logic [15:0] et, logic [15:0] op,
                                     logic [47:0] mac, logic [31:0] sip,
                                     logic [31:0] tip, int len, int mid_at,
                                     logic [31:0] mid_ip);
    step_t s;
    s.what = ST_FRAME;
    s.chk = c;
    s.etype = et;
    s.op = op;
    s.mac = mac;
    s.sip = sip;
    s.tip = tip;
    s.len = len;
    s.mid_at = mid_at;
    s.ip = mid_ip;
    s.junk = 1'b0;
    return s;
  endfunction

  function automatic step_t lookup_step(chk_e c, logic [31:0] ip, logic [47:0] mac);
    step_t s;
    s = arp_step(c, 16'd0, 16'd0, mac, 32'd0, 32'd0, 0, -1, ip);
    s.what = ST_LOOKUP;
    return s;
  endfunction

  function automatic step_t reg_step(step_e w, logic [47:0] v);
    step_t s;
    s = arp_step(CHK_MODEL, 16'd0, 16'd0, v, 32'd0, 32'd0, 0, -1, 32'd0);
    s.what = w;
    return s;
  endfunction

  function automatic step_t random_step();
    step_t s;
    int r;
    logic [31:0] pick;
    pick = ($urandom_range(99) < 60) ? peer_pool[$urandom_range(3)] : $urandom;
    if ($urandom_range(99) < 70) return lookup_step(CHK_MODEL, pick, 48'd0);
    s = arp_step(CHK_MODEL, ETYPE_ARP, ARP_OPC_REQUEST, 48'({$urandom, $urandom}), pick,
                 ($urandom_range(99) < 60) ? stn_ip : $urandom, 42, -1,
                 peer_pool[$urandom_range(3)]);
    r = $urandom_range(99);
    if (r < 15) s.op = ARP_OPC_REPLY;
    else if (r < 25) s.op = 16'($urandom_range(3));
    else if (r < 30) s.op = 16'($urandom);
    r = $urandom_range(99);
    if (r < 8) s.etype = 16'($urandom);
    else if (r < 13) s.etype = ETYPE_IPV4;
    r = $urandom_range(99);
    if (r < 70) s.len = $urandom_range(48, ARP_FRAME_LEN);
    else if (r < 85) s.len = $urandom_range(ARP_FRAME_LEN - 1, 1);
    else s.len = $urandom_range(FRAME_CAP + 4, FRAME_CAP - 4);
    if ($urandom_range(99) < 15) s.mid_at = $urandom_range(s.len - 1);
    s.junk = ($urandom_range(99) < 20);
    return s;
  endfunction

  task automatic send_item(logic c, logic [7:0] b, logic e, logic [31:0] q);
    cfg_valid <= 1'b0;
    while ($urandom_range(99) < idle_pct) begin
      item_valid <= 1'b0;
      @(negedge clk);
    end
    item_valid <= 1'b1;
    cmd <= c;
    rx_byte <= b;
    frame_end <= e;
    query_ip <= q;
    // hold the word until taken
    do @(posedge clk); while (item_stall);
    @(negedge clk);
  endtask

  task automatic write_reg(logic idx, logic [47:0] v);
    item_valid <= 1'b0;
    cfg_valid <= 1'b0;
    // drain all pending words before touching the registers
    while (pending_words.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  task automatic send_frame(step_t s);
    logic [ARP_FRAME_LEN*8-1:0] hdr;
    logic [7:0] b;
    hdr = {48'({$urandom, $urandom}), 48'({$urandom, $urandom}), s.etype, ARP_HTYPE_ETH,
           ETYPE_IPV4, ARP_HLEN, ARP_PLEN, s.op, s.mac, s.sip, 48'({$urandom, $urandom}),
           s.tip};
    if (s.junk) hdr[(ARP_FRAME_LEN-POS_OP)*8 +: 48] = 48'({$urandom, $urandom});
    row_chk = s.chk;
    for (int k = 0; k < s.len; k++) begin
      if (k == s.mid_at) send_item(CMD_LOOKUP, 8'($urandom), 1'($urandom), s.ip);
      b = (k < ARP_FRAME_LEN) ? hdr[(ARP_FRAME_LEN-1-k)*8 +: 8] : 8'($urandom);
      send_item(CMD_RX_BYTE, b, k == s.len - 1, $urandom);
    end
    row_chk = CHK_MODEL;
  endtask

  task automatic run_step(step_t s);
    case (s.what)
      ST_SET_MAC: write_reg(REG_OWN_MAC, s.mac);
      ST_SET_IP: write_reg(REG_OWN_IP, {16'($urandom), s.mac[31:0]});
      ST_LOOKUP: begin
        row_chk = s.chk;
        typed_mac = s.mac;
        send_item(CMD_LOOKUP, 8'($urandom), 1'($urandom), s.ip);
        row_chk = CHK_MODEL;
      end
      default: send_frame(s);
    endcase
  endtask

  initial begin
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = REG_OWN_MAC;
    cfg_data = '0;
    item_valid = 1'b0;
    cmd = CMD_RX_BYTE;
    rx_byte = '0;
    frame_end = 1'b0;
    query_ip = '0;
    foreach (peer_pool[i]) peer_pool[i] = $urandom;

    // empty cache after reset: even address zero misses
    plan.push_back(lookup_step(CHK_MODEL, 32'h0, 48'h0));
    plan.push_back(arp_step(CHK_MODEL, ETYPE_ARP, ARP_OPC_REQUEST, 48'hFFFF_FFFF_FFFF,
                            32'hFFFF_FFFF, 32'h0, 42, -1, 32'h0));
    plan.push_back(lookup_step(CHK_HIT, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF));
    plan.push_back(reg_step(ST_SET_MAC, 48'h0200_5E10_2030));
    plan.push_back(reg_step(ST_SET_IP, 48'hC0A8_0001));
    // replies refresh the cache but send nothing
    plan.push_back(arp_step(CHK_NONE, ETYPE_ARP, ARP_OPC_REPLY, 48'h3CA1_5E00_7701,
                            32'h0A00_0002, 32'hC0A8_0001, 42, -1, 32'h0));
    plan.push_back(lookup_step(CHK_HIT, 32'h0A00_0002, 48'h3CA1_5E00_7701));
    // short frames: drop
    plan.push_back(arp_step(CHK_NONE, ETYPE_ARP, ARP_OPC_REQUEST, 48'h0, 32'h0A00_0009,
                            32'hC0A8_0001, 41, -1, 32'h0));
    plan.push_back(lookup_step(CHK_HIT, 32'h0A00_0002, 48'h3CA1_5E00_7701));
    // lookup in the middle of a frame sees the old entry
    plan.push_back(arp_step(CHK_MODEL, ETYPE_ARP, ARP_OPC_REQUEST, 48'h0200_0000_0001,
                            32'h0A00_0010, 32'hC0A8_0001, 42, 20, 32'h0A00_0002));
    plan.push_back(reg_step(ST_SET_MAC, 48'hFFFF_FFFF_FFFF));
    plan.push_back(reg_step(ST_SET_IP, 48'hFFFF_FFFF));
    // long frames: position saturates, header is taken from the first bytes only
    plan.push_back(arp_step(CHK_MODEL, ETYPE_ARP, ARP_OPC_REQUEST, 48'h0123_4567_89AB,
                            32'h0102_0304, 32'hFFFF_FFFF, FRAME_CAP + 2, 50,
                            32'h0102_0304));
    plan.push_back(lookup_step(CHK_HIT, 32'h0102_0304, 48'h0123_4567_89AB));
    plan.push_back(reg_step(ST_SET_MAC, 48'h0));
    plan.push_back(reg_step(ST_SET_IP, 48'h0));
    plan.push_back(lookup_step(CHK_MODEL, 32'h1234_5678, 48'h0));

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (plan[i]) run_step(plan[i]);

    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = idle_mix[ph];
      stall_pct = stall_mix[ph];
      run_step(reg_step(ST_SET_MAC, 48'({$urandom, $urandom})));
      run_step(reg_step(ST_SET_IP, 48'($urandom)));
      repeat (RANDOM_STEPS) run_step(random_step());
    end

    item_valid <= 1'b0;
    cfg_valid <= 1'b0;
    while (pending_words.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (pending_words.size() != 0)
      note_error($sformatf("%0d words never arrived", pending_words.size()));
    if (errors == 0) $display("arp_responder_one_entry_cache verification clean");
    else $display("arp_responder_one_entry_cache verification failed");
    $finish;
  end
endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/arpc_pkg.sv
rtl/core/arpc_jobq.sv
rtl/core/arpc_front.sv
rtl/core/arpc_emit.sv
rtl/core/arp_responder_one_entry_cache.sv
test/tb.sv
